// File: sv/swps_pkg.sv
// Package for the wheel-of-six prime sieve: sizes, the constant for the
// divide-by-six step, stage codes and the command type.
// No dependencies.
package swps_pkg;

  localparam int unsigned CANDIDATES  = 65536;
  localparam int unsigned IDX_W       = $clog2(CANDIDATES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned LIM_W       = 18;
  localparam int unsigned STRIKE_W    = 21;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_SIX = 18'd174763;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 18'd196609;

  localparam logic [1:0] STAGE_TWO   = 2'd0;
  localparam logic [1:0] STAGE_THREE = 2'd1;
  localparam logic [1:0] STAGE_WHEEL = 2'd2;

  typedef struct packed {
    logic restart;
  } cmd_t;

endpackage

// File: sv/swps_cmd_fifo.sv
// Front end of the sieve: a two-entry command queue in front of the engine.
// Depends on swps_pkg.
module swps_cmd_fifo import swps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: sv/swps_engine.sv
// Back end of the sieve: candidate bitmap, scan and strike sequencer,
// wheel size pipeline and result register.
// Depends on swps_pkg.
module swps_engine import swps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LIM_W-1:0] limit_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LIM_W-1:0] prime_value_o,
  output logic             exhausted_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_STK_A, ST_STK_B
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    clr_q;
  logic [CNT_W-1:0]    scan_q;
  logic [1:0]          stage_q;
  logic                out_valid_q, exh_q;
  logic [LIM_W-1:0]    prime_q;
  logic [STRIKE_W-1:0] a_q, b_q, step_q;
  logic [CNT_W-1:0]    stk_cnt_q;

  // Candidate bitmap, one write port and one registered read port.
  logic                mem [CANDIDATES];
  logic                mem_we, mem_wdata, rdata_q;
  logic [IDX_W-1:0]    mem_waddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[scan_q[IDX_W-1:0]];
  end

  // Wheel size from the limit, three registered steps; x/6 by reciprocal.
  logic [LIM_W:0]              x1_q, x2_q;
  logic                        lt5_1_q, lt5_2_q;
  logic [LIM_W+RECIP_W:0]      prod_q;
  logic [CNT_W-1:0]            count_q;
  logic [CNT_W-1:0]            quo;
  logic [LIM_W:0]              rem_w;
  logic [CNT_W:0]              n_w;

  assign quo   = prod_q[RECIP_SHIFT +: CNT_W];
  assign rem_w = x2_q - ({2'b0, quo} * (LIM_W+1)'(6));
  assign n_w   = {quo, 1'b0} - {{CNT_W{1'b0}}, (rem_w[2:0] <= 3'd1)};

  always_ff @(posedge clk_i) begin
    x1_q    <= {1'b0, limit_i} + (LIM_W+1)'(1);
    lt5_1_q <= (limit_i < LIM_W'(5));
    prod_q  <= x1_q * RECIP_SIX;
    x2_q    <= x1_q;
    lt5_2_q <= lt5_1_q;
    if (lt5_2_q) begin
      count_q <= '0;
    end else if (n_w > (CNT_W+1)'(CANDIDATES)) begin
      count_q <= CNT_W'(CANDIDATES);
    end else begin
      count_q <= n_w[CNT_W-1:0];
    end
  end

  // Strike set-up for the prime at wheel index scan_q.
  logic [STRIKE_W-1:0] k_w, step_w, a_w, b_w;
  always_comb begin
    if (!scan_q[0]) begin
      k_w    = STRIKE_W'(scan_q) + STRIKE_W'(2);
      step_w = (k_w << 2) + (k_w << 1) - STRIKE_W'(2);
      a_w    = (k_w << 2) + k_w - STRIKE_W'(3);
      b_w    = (k_w << 3) - k_w - STRIKE_W'(4);
    end else begin
      k_w    = STRIKE_W'(scan_q) + STRIKE_W'(1);
      step_w = (k_w << 2) + (k_w << 1) + STRIKE_W'(2);
      a_w    = (k_w << 2) + k_w;
      b_w    = (k_w << 3) - k_w + STRIKE_W'(1);
    end
  end

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && !out_valid_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_waddr = a_q[IDX_W-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        mem_waddr = clr_q;
      end
      ST_STK_A: mem_we = (a_q < STRIKE_W'(stk_cnt_q));
      ST_STK_B: begin
        mem_we    = (b_q < STRIKE_W'(stk_cnt_q));
        mem_waddr = b_q[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scan_q      <= '0;
      stage_q     <= STAGE_TWO;
      out_valid_q <= 1'b0;
      exh_q       <= 1'b0;
      prime_q     <= '0;
      a_q         <= '0;
      b_q         <= '0;
      step_q      <= '0;
      stk_cnt_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (&clr_q) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.restart) begin
              out_valid_q <= 1'b1;
              prime_q     <= '0;
              exh_q       <= 1'b0;
              scan_q      <= '0;
              stage_q     <= STAGE_TWO;
              clr_q       <= '0;
              state_q     <= ST_CLEAR;
            end else if (stage_q == STAGE_TWO && limit_i >= LIM_W'(2)) begin
              out_valid_q <= 1'b1;
              prime_q     <= LIM_W'(2);
              exh_q       <= 1'b0;
              stage_q     <= STAGE_THREE;
            end else if (stage_q <= STAGE_THREE && limit_i >= LIM_W'(3)) begin
              out_valid_q <= 1'b1;
              prime_q     <= LIM_W'(3);
              exh_q       <= 1'b0;
              stage_q     <= STAGE_WHEEL;
            end else begin
              state_q <= ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          if (scan_q >= count_q) begin
            out_valid_q <= 1'b1;
            prime_q     <= '0;
            exh_q       <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_SCAN_CHK;
          end
        end
        ST_SCAN_CHK: begin
          if (rdata_q) begin
            out_valid_q <= 1'b1;
            prime_q     <= step_w[LIM_W:1];
            exh_q       <= 1'b0;
            a_q         <= a_w;
            b_q         <= b_w;
            step_q      <= step_w;
            // The strike keeps the wheel size that held when the prime was
            // found, even if the limit is rewritten while it runs.
            stk_cnt_q   <= count_q;
            state_q     <= ST_STK_A;
          end else begin
            state_q <= ST_SCAN_RD;
          end
          scan_q <= scan_q + CNT_W'(1);
        end
        ST_STK_A: begin
          if (a_q < STRIKE_W'(stk_cnt_q)) state_q <= ST_STK_B;
          else                            state_q <= ST_IDLE;
        end
        ST_STK_B: begin
          a_q     <= a_q + step_q;
          b_q     <= b_q + step_q;
          state_q <= ST_STK_A;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign clearing_o    = (state_q == ST_CLEAR);
  assign out_valid_o   = out_valid_q;
  assign prime_value_o = prime_q;
  assign exhausted_o   = exh_q;

  // A command is only taken when the result slot is empty.
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !out_valid_q)
    else $error("command taken while a result is still pending");

  // An exhaustion result always carries a zero value.
  a_exh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && exh_q) |-> (prime_q == '0))
    else $error("exhaustion result with non-zero value");

  // A restart always starts a clearing pass of the bitmap.
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.restart) |=> (state_q == ST_CLEAR && clr_q == '0))
    else $error("restart did not start a clearing pass");

  // Strike writes never touch positions at or below the prime's own index.
  a_strike_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STK_A && mem_we) |-> (a_q >= STRIKE_W'(scan_q)))
    else $error("strike write behind the scan position");

endmodule

// File: sv/wheel_six_prime_sieve_core.sv
// Top level of the wheel-of-six prime sieve: handshakes, command queue and
// sieve engine. Depends on swps_pkg, swps_cmd_fifo and swps_engine.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------
//   in      | in        | in_valid/in_ready  | restart_i
//   out     | out       | out_valid/out_ready| prime_value_o, exhausted_o
//   cfg     | in        | cfg_valid/cfg_ready| upper_limit_i
//
// A request for 2 or 3 is answered through the command queue and the result
// register. A wheel request visits ST_SCAN_RD and ST_SCAN_CHK per bitmap
// position scanned, set by the single read port of the bitmap; after the prime
// is given out the engine strikes each pair of multiples in ST_STK_A and
// ST_STK_B and finishes in ST_STK_A. After reset and after every restart the
// bitmap is refilled, one position a cycle, over all 65536 positions; no
// transaction is accepted on the input channel meanwhile. A limit write holds
// off input while the wheel size is recomputed. A stalled output holds the
// result and the queue in front of the engine keeps taking up to two requests.
module wheel_six_prime_sieve_core import swps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LIM_W-1:0] prime_value_o,
  output logic             exhausted_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LIM_W-1:0] upper_limit_i
);

  logic [LIM_W-1:0] limit_q;
  logic [1:0]       settle_q;
  logic             fifo_full, fifo_valid, fifo_pop, clearing, push;
  cmd_t             in_cmd, fifo_cmd;

  // Limit always writable; the user, not the block, writes only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      settle_q <= 2'd0;
    end else if (cfg_valid_i) begin
      limit_q  <= upper_limit_i;
      settle_q <= 2'd3;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // Requests wait on a full queue, in a refill and while the wheel size settles.
  assign in_ready_o     = !fifo_full && !clearing && (settle_q == 2'd0);
  assign push           = in_valid_i && in_ready_o;
  assign in_cmd.restart = restart_i;

  swps_cmd_fifo u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (in_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .cmd_o   (fifo_cmd)
  );

  swps_engine u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit_q),
    .cmd_valid_i   (fifo_valid),
    .cmd_i         (fifo_cmd),
    .cmd_pop_o     (fifo_pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prime_value_o (prime_value_o),
    .exhausted_o   (exhausted_o)
  );

endmodule

// File: dv/tb_wheel_six_prime_sieve_core.sv
// Self-checking testbench for wheel_six_prime_sieve_core: drives next-prime and
// restart transactions and limit writes, predicts every answer with an in-bench sieve model.
// Depends on swps_pkg and wheel_six_prime_sieve_core.
`timescale 1ns / 1ps

module tb_wheel_six_prime_sieve_core;
  import swps_pkg::*;

  localparam int unsigned IDLE_LIMIT = 600000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             req_valid = 1'b0;
  logic             req_ready;
  logic             req_restart = 1'b0;
  logic             ans_valid;
  logic             ans_ready = 1'b0;
  logic [LIM_W-1:0] ans_prime;
  logic             ans_exhausted;
  logic             lim_valid = 1'b0;
  logic             lim_ready;
  logic [LIM_W-1:0] lim_data = '0;

  typedef struct packed {
    logic [LIM_W-1:0] prime;
    logic             exhausted;
  } answer_t;

  bit      pending_reqs[$];
  answer_t expected_answers[$];
  int      mismatches = 0;

  // Predictor state: its own copy of the bitmap, scan pointer, stage and limit.
  bit               sieve_bits [CANDIDATES];
  int unsigned      scan_pos;
  logic [1:0]       prime_stage;
  logic [LIM_W-1:0] model_limit;

  wheel_six_prime_sieve_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_ready_o    (req_ready),
    .restart_i     (req_restart),
    .out_valid_o   (ans_valid),
    .out_ready_i   (ans_ready),
    .prime_value_o (ans_prime),
    .exhausted_o   (ans_exhausted),
    .cfg_valid_i   (lim_valid),
    .cfg_ready_o   (lim_ready),
    .upper_limit_i (lim_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned wheel_positions();
    longint unsigned q, r, n;
    if (model_limit < 5) return 0;
    q = (longint'(model_limit) + 1) / 6;
    r = (longint'(model_limit) + 1) % 6;
    n = 2 * q - ((r <= 1) ? 1 : 0);
    if (n > CANDIDATES) n = CANDIDATES;
    return n;
  endfunction

  // Clears the multiples of the prime at wheel index idx; returns that prime.
  function automatic longint unsigned strike_multiples(longint unsigned idx,
                                                       longint unsigned count);
    longint unsigned k, step, a, b;
    if (idx[0] == 1'b0) begin
      k = idx + 2;
      step = 6 * k - 2;
      a = step - k - 1;
      b = step + k - 2;
    end else begin
      k = idx + 1;
      step = 6 * k + 2;
      a = step - k - 2;
      b = step + k - 1;
    end
    while (a < count) begin
      sieve_bits[a] = 1'b0;
      if (b < count) sieve_bits[b] = 1'b0;
      a += step;
      b += step;
    end
    return step >> 1;
  endfunction

  function automatic void refill_sieve();
    foreach (sieve_bits[i]) sieve_bits[i] = 1'b1;
    scan_pos = 0;
    prime_stage = STAGE_TWO;
  endfunction

  function automatic answer_t next_prime(bit restart);
    answer_t res;
    longint unsigned count, i;
    res = '0;
    if (restart) begin
      refill_sieve();
      return res;
    end
    if (prime_stage == STAGE_TWO && model_limit >= 2) begin
      prime_stage = STAGE_THREE;
      res.prime = LIM_W'(2);
      return res;
    end
    if ((prime_stage == STAGE_TWO || prime_stage == STAGE_THREE) && model_limit >= 3) begin
      prime_stage = STAGE_WHEEL;
      res.prime = LIM_W'(3);
      return res;
    end
    count = wheel_positions();
    i = scan_pos;
    while (i < count && !sieve_bits[i]) i++;
    if (i >= count) begin
      scan_pos = 32'(i & 17'h1FFFF);
      res.exhausted = 1'b1;
      return res;
    end
    res.prime = LIM_W'(strike_multiples(i, count) & 18'h3FFFF);
    scan_pos = 32'((i + 1) & 17'h1FFFF);
    return res;
  endfunction

  // Sender: bursts of random length separated by random gaps, some bursts
  // with no gap at all. Valid is held with a stable payload until accepted.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      req_restart <= 1'b0;
    end else if (!(req_valid && !req_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_valid <= 1'b1;
        req_restart <= pending_reqs.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern steps in turn through always ready, half random
  // stalls, heavy random stalls and light random stalls.
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    stall_tick++;
    case ((stall_tick / 400) % 4)
      0: ans_ready <= 1'b1;
      1: ans_ready <= ($urandom_range(0, 1) == 1);
      2: ans_ready <= ($urandom_range(0, 7) == 0);
      default: ans_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Checker and predictor together, so the queue of expected answers is only
  // touched by one process. Limit writes update the predictor's limit.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n) begin
      if (ans_valid && ans_ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected answer: prime %0d exhausted %0b", ans_prime, ans_exhausted);
        end else begin
          exp_ans = expected_answers.pop_front();
          if (ans_prime !== exp_ans.prime || ans_exhausted !== exp_ans.exhausted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected prime %0d exhausted %0b, got %0d %0b",
                       exp_ans.prime, exp_ans.exhausted, ans_prime, ans_exhausted);
          end
        end
      end
      if (lim_valid && lim_ready) model_limit = lim_data;
      if (req_valid && req_ready) expected_answers.push_back(next_prime(req_restart));
    end
  end

  // Watchdog: the longest honest silence is a bitmap refill, or a scan across
  // the whole wheel, each well under the limit.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (ans_valid && ans_ready) || (lim_valid && lim_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_answers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] value);
    wait_idle();
    lim_valid <= 1'b1;
    lim_data <= value;
    do @(posedge clk);
    while (!lim_ready);
    lim_valid <= 1'b0;
  endtask

  task automatic queue_requests(int n);
    repeat (n) pending_reqs.push_back(1'b0);
  endtask

  initial begin
    int restarts_left;
    int phase_len;
    logic [LIM_W-1:0] lim;
    refill_sieve();
    model_limit = LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty limit, limits that admit only two or only three,
    // the limit just below the wheel, the first wheel prime, a limit raised
    // without restart, a restart, and the reset limit, the largest the bitmap covers.
    write_limit(0);
    queue_requests(2);
    write_limit(2);
    queue_requests(2);
    write_limit(3);
    queue_requests(2);
    write_limit(4);
    queue_requests(1);
    write_limit(5);
    queue_requests(2);
    write_limit(30);
    queue_requests(6);
    pending_reqs.push_back(1'b1);
    write_limit(LIMIT_RESET);
    queue_requests(8);

    // Random part: every phase sets a limit, mostly restarts and then asks
    // for primes; restarts are few because each one refills the bitmap.
    restarts_left = 5;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: lim = $urandom_range(0, 12);
        1: lim = $urandom_range(13, 400);
        2: lim = $urandom_range(400, 4000);
        3: lim = $urandom_range(4000, 40000);
        default: lim = $urandom_range(40000, LIMIT_RESET);
      endcase
      write_limit(lim);
      if (restarts_left > 0 && $urandom_range(0, 3) != 0) begin
        pending_reqs.push_back(1'b1);
        restarts_left--;
      end
      phase_len = $urandom_range(200, 240);
      for (int n = 0; n < phase_len; n++) begin
        if (restarts_left > 0 && $urandom_range(0, 199) == 0) begin
          pending_reqs.push_back(1'b1);
          restarts_left--;
        end else begin
          pending_reqs.push_back(1'b0);
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
